FILE: rtl/core/gps_pkg.sv
// ----------------------------------------------------------------------------
// gps_pkg
// Shared constants, register codes and pipeline latencies of the polar sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package gps_pkg;

  typedef enum logic [1:0] {
    REG_MEAN   = 2'd0,
    REG_SPREAD = 2'd1,
    REG_MODE   = 2'd2
  } gps_reg_t;

  // 2 ln2 and ln2 in Q.24
  localparam logic [24:0] TWO_LN2_Q24 = 25'd23258160;
  localparam logic [23:0] LN2_Q24     = 24'd11629080;

  // floor(2^32 / k) for the series divisors
  localparam logic [32:0] RECIP [1:12] = '{
    33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
    33'd858993459,  33'd715827882,  33'd613566756,  33'd536870912,
    33'd477218588,  33'd429496729,  33'd390451572,  33'd357913941
  };

  localparam int LOG_LAT  = 41;
  localparam int DIV_LAT  = 31;
  localparam int SQRT_LAT = 32;
  localparam int EXP_LAT  = 45;
  localparam int BR_LAT   = LOG_LAT + SQRT_LAT;
  localparam int QDLY     = LOG_LAT - DIV_LAT;

endpackage

`default_nettype wire

FILE: rtl/core/gaussian_polar_sampler.sv
// ----------------------------------------------------------------------------
// gaussian_polar_sampler
// Polar-method normal / lognormal deviate generator, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//  in       in_valid/in_ready    uniform_a, uniform_b
//  out      out_valid/out_ready  deviate
//
//  One item enters per cycle while in_ready is high; the latency to the output
//  register is set by the log2 squaring chain, the root pipeline and the exp series.
//  Rejected pairs travel as bubbles and give no item.
//  rst clears valid bits and registers mean=0, spread=1.0, mode=0.
//  A two-entry output (register plus skid) holds results; in_ready drops
//  only while the skid entry is full, and the whole pipe then holds.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_polar_sampler
  import gps_pkg::*;
#(
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic        [1:0]  cfg_index,
  input  wire logic        [31:0] cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic        [31:0] uniform_a,
  input  wire logic        [31:0] uniform_b,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed      [31:0] deviate
);

  localparam int          DROP = (SAMPLE_BITS >= 32) ? 0 : 32 - SAMPLE_BITS;
  localparam logic [31:0] MASK = 32'hFFFF_FFFF << DROP;

  logic signed [31:0] mean;
  logic [30:0]        spread;
  logic               mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean   <= '0;
      spread <= 31'd16777216;
      mode   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MEAN:   mean   <= cfg_data;
        REG_SPREAD: spread <= cfg_data[30:0];
        REG_MODE:   mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_valid;
  logic [31:0] skid_data;

  assign en       = !skid_valid;
  assign in_ready = en;

  // front: coordinates, squares, radius
  logic [31:0] ua;
  logic [31:0] ub;
  assign ua = uniform_a & MASK;
  assign ub = uniform_b & MASK;

  logic        v1, v2, v3;
  logic        n1, n2, n3;
  logic [31:0] ma, mb;
  logic [63:0] sqa, sqb2, sqb3, rad3;
  logic [63:0] rad_sum;
  assign rad_sum = sqa + sqb2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2 && (rad_sum != '0) && (rad_sum <= 64'h4000_0000_0000_0000);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma   <= ua[31] ? {1'b0, ua[30:0]} : 32'h8000_0000 - ua;
      mb   <= ub[31] ? {1'b0, ub[30:0]} : 32'h8000_0000 - ub;
      n1   <= !ub[31];
      sqa  <= 64'(ma) * 64'(ma);
      sqb2 <= 64'(mb) * 64'(mb);
      n2   <= n1;
      rad3 <= rad_sum;
      sqb3 <= sqb2;
      n3   <= n2;
    end
  end

  // branches: -2 ln(rad) and cb^2/rad, then their roots
  logic [63:0] big_l;
  logic [30:0] quo;
  logic [31:0] s_root, c_root;
  logic [30:0] qd [1:QDLY];

  gps_log u_log (.clk(clk), .en(en), .rad(rad3), .big_l(big_l));
  gps_div u_div (.clk(clk), .en(en), .num(sqb3), .den(rad3), .quo(quo));

  always_ff @(posedge clk) begin
    if (en) begin
      qd[1] <= quo;
      for (int i = 2; i <= QDLY; i++) begin
        qd[i] <= qd[i-1];
      end
    end
  end

  gps_sqrt u_sqrt_s (.clk(clk), .en(en), .radicand(big_l), .root(s_root));
  gps_sqrt u_sqrt_c (
    .clk(clk), .en(en), .radicand({3'b000, qd[QDLY], 30'd0}), .root(c_root)
  );

  logic vl [1:BR_LAT];
  logic nl [1:BR_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= BR_LAT; i++) begin
        vl[i] <= 1'b0;
      end
    end else if (en) begin
      vl[1] <= v3;
      for (int i = 2; i <= BR_LAT; i++) begin
        vl[i] <= vl[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nl[1] <= n3;
      for (int i = 2; i <= BR_LAT; i++) begin
        nl[i] <= nl[i-1];
      end
    end
  end

  // back: g, scaling, offset
  logic               v4, v5, v6;
  logic               n4, n5;
  logic [63:0]        gp;
  logic [28:0]        gmag;
  logic [59:0]        sp;
  logic [35:0]        prod;
  logic signed [37:0] z;
  logic signed [37:0] zn;

  assign gp = 64'(c_root) * 64'(s_root);
  assign sp = 60'(spread) * 60'(gmag);
  assign zn = 38'(mean) + (n5 ? -$signed({2'b00, prod}) : $signed({2'b00, prod}));

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v4 <= vl[BR_LAT];
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gmag <= gp[58:30];
      n4   <= nl[BR_LAT];
      prod <= sp[59:24];
      n5   <= n4;
      z    <= zn;
    end
  end

  // normal path saturation, matched to the exp latency
  logic [31:0] lin;
  logic [31:0] exp_res;
  logic [31:0] ld [1:EXP_LAT];
  logic        vx [1:EXP_LAT];

  always_comb begin
    if (z > 38'sd2147483647) begin
      lin = 32'h7FFF_FFFF;
    end else if (z < -38'sd2147483648) begin
      lin = 32'h8000_0000;
    end else begin
      lin = z[31:0];
    end
  end

  gps_exp u_exp (.clk(clk), .en(en), .z(z), .res(exp_res));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= EXP_LAT; i++) begin
        vx[i] <= 1'b0;
      end
    end else if (en) begin
      vx[1] <= v6;
      for (int i = 2; i <= EXP_LAT; i++) begin
        vx[i] <= vx[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ld[1] <= lin;
      for (int i = 2; i <= EXP_LAT; i++) begin
        ld[i] <= ld[i-1];
      end
    end
  end

  logic        fv;
  logic [31:0] fd;
  assign fv = vx[EXP_LAT];
  assign fd = mode ? exp_res : ld[EXP_LAT];

  // output register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || out_ready) begin
      out_valid <= fv;
    end else if (fv) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        deviate <= skid_data;
      end
    end else if (!out_valid || out_ready) begin
      if (fv) begin
        deviate <= fd;
      end
    end else if (fv) begin
      skid_data <= fd;
    end
  end

`ifndef SYNTHESIS
  a_skid_has_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry full while output register empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_ready) |=> (out_valid && !skid_valid))
    else $error("skid entry not moved to output register");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(v6) && $stable(z)))
    else $error("pipeline moved while stalled");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/gps_sqrt.sv
// ----------------------------------------------------------------------------
// gps_sqrt
// Pipelined floor square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gps_sqrt
  import gps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] radicand,
  output logic      [31:0] root
);

  logic [32:0] sr [0:32];
  logic [31:0] sq [0:32];
  logic [63:0] sd [0:32];

  assign sr[0] = '0;
  assign sq[0] = '0;
  assign sd[0] = radicand;

  for (genvar i = 1; i <= 32; i++) begin : g_step
    logic [34:0] rt;
    logic [34:0] tr;
    assign rt = {sr[i-1], sd[i-1][63:62]};
    assign tr = {1'b0, sq[i-1], 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        sd[i] <= {sd[i-1][61:0], 2'b00};
        if (rt >= tr) begin
          sr[i] <= 33'(rt - tr);
          sq[i] <= {sq[i-1][30:0], 1'b1};
        end else begin
          sr[i] <= rt[32:0];
          sq[i] <= {sq[i-1][30:0], 1'b0};
        end
      end
    end
  end

  assign root = sq[32];

endmodule

`default_nettype wire

FILE: rtl/core/gps_div.sv
// ----------------------------------------------------------------------------
// gps_div
// Pipelined restoring divider: quo = floor(num * 2^30 / den), num <= den.
// ----------------------------------------------------------------------------
`default_nettype none

module gps_div
  import gps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] num,
  input  wire logic [63:0] den,
  output logic      [30:0] quo
);

  logic [63:0] dr [1:31];
  logic [63:0] dd [1:31];
  logic [30:0] dq [1:31];

  always_ff @(posedge clk) begin
    if (en) begin
      dd[1] <= den;
      if (num >= den) begin
        dr[1] <= num - den;
        dq[1] <= 31'd1;
      end else begin
        dr[1] <= num;
        dq[1] <= '0;
      end
    end
  end

  for (genvar i = 2; i <= 31; i++) begin : g_step
    logic [63:0] rt;
    assign rt = {dr[i-1][62:0], 1'b0};
    always_ff @(posedge clk) begin
      if (en) begin
        dd[i] <= dd[i-1];
        if (rt >= dd[i-1]) begin
          dr[i] <= rt - dd[i-1];
          dq[i] <= {dq[i-1][29:0], 1'b1};
        end else begin
          dr[i] <= rt;
          dq[i] <= {dq[i-1][29:0], 1'b0};
        end
      end
    end
  end

  assign quo = dq[31];

endmodule

`default_nettype wire

FILE: rtl/core/gps_log.sv
// ----------------------------------------------------------------------------
// gps_log
// Normalizes the squared radius, takes log2 by repeated squaring and scales
// to -2 ln(rad) in Q.48.
// ----------------------------------------------------------------------------
`default_nettype none

module gps_log
  import gps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] rad,
  output logic      [63:0] big_l
);

  logic [63:0] nm [0:6];
  logic [5:0]  nc [0:6];

  assign nm[0] = rad;
  assign nc[0] = '0;

  for (genvar j = 0; j < 6; j++) begin : g_norm
    localparam int SH = 32 >> j;
    always_ff @(posedge clk) begin
      if (en) begin
        if (nm[j][63 -: SH] == '0) begin
          nm[j+1] <= nm[j] << SH;
          nc[j+1] <= nc[j] + 6'(SH);
        end else begin
          nm[j+1] <= nm[j];
          nc[j+1] <= nc[j];
        end
      end
    end
  end

  logic [31:0] lx [0:32];
  logic [31:0] lf [0:32];
  logic [5:0]  le [0:32];

  assign lx[0] = nm[6][63:32];
  assign lf[0] = '0;
  assign le[0] = nc[6] - 6'd1;

  for (genvar i = 1; i <= 32; i++) begin : g_sq
    logic [63:0] sq;
    assign sq = 64'(lx[i-1]) * 64'(lx[i-1]);
    always_ff @(posedge clk) begin
      if (en) begin
        le[i] <= le[i-1];
        if (sq[63]) begin
          lx[i] <= sq[63:32];
          lf[i] <= {lf[i-1][30:0], 1'b1};
        end else begin
          lx[i] <= sq[62:31];
          lf[i] <= {lf[i-1][30:0], 1'b0};
        end
      end
    end
  end

  logic [37:0] t;
  logic [43:0] ph;
  logic [43:0] pl;

  always_ff @(posedge clk) begin
    if (en) begin
      t     <= {le[32], 32'd0} - {6'd0, lf[32]};
      ph    <= 44'(t[37:19]) * 44'(TWO_LN2_Q24);
      pl    <= 44'(t[18:0]) * 44'(TWO_LN2_Q24);
      big_l <= ({1'b0, ph, 19'd0} + {20'd0, pl}) >> 8;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/gps_exp.sv
// ----------------------------------------------------------------------------
// gps_exp
// Pipelined exp() for Q.24 input: range split by ln2, 12-term series in Q.30,
// power-of-two shift and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module gps_exp
  import gps_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [37:0] z,
  output logic             [31:0] res
);

  typedef struct packed {
    logic        hi;
    logic        lo;
    logic [5:0]  q;
    logic [29:0] r30;
    logic [31:0] sum;
  } exp_side_t;

  logic [37:0] zs;
  assign zs = z + 38'sd372130560;

  logic [28:0] dr [0:6];
  logic [5:0]  dq [0:6];
  logic        dh [0:6];
  logic        dl [0:6];

  always_ff @(posedge clk) begin
    if (en) begin
      dh[0] <= (z >= 38'sd83886080);
      dl[0] <= (z < -38'sd301989888);
      dr[0] <= zs[28:0];
      dq[0] <= '0;
    end
  end

  for (genvar j = 0; j < 6; j++) begin : g_red
    localparam logic [28:0] C = 29'(LN2_Q24) << (5 - j);
    always_ff @(posedge clk) begin
      if (en) begin
        dh[j+1] <= dh[j];
        dl[j+1] <= dl[j];
        if (dr[j] >= C) begin
          dr[j+1] <= dr[j] - C;
          dq[j+1] <= {dq[j][4:0], 1'b1};
        end else begin
          dr[j+1] <= dr[j];
          dq[j+1] <= {dq[j][4:0], 1'b0};
        end
      end
    end
  end

  exp_side_t   sa [1:12];
  exp_side_t   sb [1:12];
  exp_side_t   sc [0:12];
  logic [30:0] pa [1:12];
  logic [30:0] pb [1:12];
  logic [30:0] qb [1:12];
  logic [30:0] tm [0:12];

  assign sc[0] = '{hi: dh[6], lo: dl[6], q: dq[6], r30: {dr[6][23:0], 6'd0},
                   sum: 32'd1073741824};
  assign tm[0] = 31'd1073741824;

  for (genvar k = 1; k <= 12; k++) begin : g_term
    logic [60:0] pp;
    logic [63:0] pr;
    logic [30:0] rem;
    logic [30:0] tn;
    assign pp  = 61'(tm[k-1]) * 61'(sc[k-1].r30);
    assign pr  = 64'(pa[k]) * 64'(RECIP[k]);
    assign rem = pb[k] - 31'(qb[k] * 31'(k));
    assign tn  = qb[k] + 31'(rem >= 31'(k));
    always_ff @(posedge clk) begin
      if (en) begin
        pa[k] <= pp[60:30];
        sa[k] <= sc[k-1];
        pb[k] <= pa[k];
        qb[k] <= pr[62:32];
        sb[k] <= sa[k];
        tm[k] <= tn;
        sc[k] <= '{hi: sb[k].hi, lo: sb[k].lo, q: sb[k].q, r30: sb[k].r30,
                   sum: sb[k].sum + 32'(tn)};
      end
    end
  end

  logic [33:0] val;
  logic        fh;
  logic        fl;

  always_ff @(posedge clk) begin
    if (en) begin
      fh <= sc[12].hi;
      fl <= sc[12].lo;
      if (sc[12].q >= 6'd38) begin
        val <= {2'b00, sc[12].sum} << (sc[12].q - 6'd38);
      end else begin
        val <= {2'b00, sc[12].sum} >> (6'd38 - sc[12].q);
      end
      if (fh) begin
        res <= 32'h7FFF_FFFF;
      end else if (fl) begin
        res <= '0;
      end else if (val > 34'h0_7FFF_FFFF) begin
        res <= 32'h7FFF_FFFF;
      end else begin
        res <= val[31:0];
      end
    end
  end

endmodule

`default_nettype wire
